// ----- rtl/hsv_to_rgb_converter_unit_assert.svh -----
// Assertion macros shared by the converter RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HSVC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HSVC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HSVC_ASSERT(label, clk, rst, prop, msg)
`define HSVC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/hsvc_pkg.sv -----
// Shared constants, sector codes and queue word type for the HSV to RGB converter.
// No dependencies.
package hsvc_pkg;

   localparam int unsigned HUE_W   = 16;
   localparam int unsigned PCT_W   = 7;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned TURN_W  = 9;   // hue after reduction, 0..359
   localparam int unsigned REM_W   = 6;   // offset inside a sector, 0..59

   localparam int unsigned FULL_TURN   = 360;
   localparam int unsigned SECTOR_SPAN = 60;
   localparam int unsigned PERCENT_MAX = 100;
   localparam int unsigned CHANNEL_MAX = 255;

   // reciprocal multipliers, exact floor over the ranges that reach them
   localparam int unsigned TURN_SHIFT    = 24;
   localparam int unsigned RECIP_TURN    = (1 << TURN_SHIFT) / FULL_TURN + 1;
   localparam int unsigned PERCENT_SHIFT = 22;
   localparam int unsigned RECIP_PERCENT = (1 << PERCENT_SHIFT) / PERCENT_MAX + 1;
   localparam int unsigned SPAN_SHIFT    = 20;
   localparam int unsigned RECIP_SPAN    = (1 << SPAN_SHIFT) / SECTOR_SPAN + 1;
   // v*255/100 folded into one constant
   localparam int unsigned TOP_SCALE     = CHANNEL_MAX * RECIP_PERCENT;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      SECTOR_RG = 3'd0,
      SECTOR_GR = 3'd1,
      SECTOR_GB = 3'd2,
      SECTOR_BG = 3'd3,
      SECTOR_BR = 3'd4,
      SECTOR_RB = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type           sector;
      logic [REM_W-1:0]     rem;
      logic [PCT_W-1:0]     sat_inv;   // 100 - clipped saturation
      logic [PCT_W-1:0]     val;       // clipped brightness
   } word_type;

endpackage

// ----- rtl/hsvc_front.sv -----
// Front end: takes request words, clips percentages, reduces hue and classifies sector.
// Depends on hsvc_pkg and the assertion header.
`include "hsv_to_rgb_converter_unit_assert.svh"
module hsvc_front import hsvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [PCT_W-1:0]  req_saturation,
   input  logic [PCT_W-1:0]  req_brightness,
   input  logic              q_full,
   output logic              q_push,
   output word_type          q_word
);

   logic              f1_valid_ff, f1_valid_in;
   logic [HUE_W-1:0]  f1_hue_ff;
   logic [7:0]        f1_quot_ff;
   logic [PCT_W-1:0]  f1_sinv_ff;
   logic [PCT_W-1:0]  f1_val_ff;
   logic              f2_valid_ff, f2_valid_in;
   logic [TURN_W-1:0] f2_turn_ff;
   logic [PCT_W-1:0]  f2_sinv_ff;
   logic [PCT_W-1:0]  f2_val_ff;

   logic              f1_load, f2_load;
   logic [31:0]       quot_prod;
   logic [PCT_W-1:0]  sat_clip, val_clip;
   logic [16:0]       turn_mul, turn_diff;
   logic [TURN_W-1:0] sec_base;
   sector_type        sector;

   assign f2_load   = !f2_valid_ff || !q_full;
   assign f1_load   = !f1_valid_ff || f2_load;
   assign req_ready = f1_load;
   assign q_push    = f2_valid_ff && !q_full;

   assign quot_prod = 32'(req_hue) * 32'(RECIP_TURN);
   assign sat_clip  = (req_saturation > PCT_W'(PERCENT_MAX)) ? PCT_W'(PERCENT_MAX)
                                                             : req_saturation;
   assign val_clip  = (req_brightness > PCT_W'(PERCENT_MAX)) ? PCT_W'(PERCENT_MAX)
                                                             : req_brightness;

   assign turn_mul  = 17'(f1_quot_ff) * 17'(FULL_TURN);
   assign turn_diff = 17'(f1_hue_ff) - turn_mul;

   assign f1_valid_in = f1_load ? req_valid : f1_valid_ff;
   assign f2_valid_in = f2_load ? f1_valid_ff : f2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_load) begin
         f1_hue_ff  <= req_hue;
         f1_quot_ff <= quot_prod[TURN_SHIFT +: 8];
         f1_sinv_ff <= PCT_W'(PERCENT_MAX) - sat_clip;
         f1_val_ff  <= val_clip;
      end
      if (f2_load) begin
         f2_turn_ff <= turn_diff[TURN_W-1:0];
         f2_sinv_ff <= f1_sinv_ff;
         f2_val_ff  <= f1_val_ff;
      end
   end

   // sector by range compare on the reduced hue
   always_comb begin
      if (f2_turn_ff < TURN_W'(SECTOR_SPAN)) begin
         sector   = SECTOR_RG;
         sec_base = '0;
      end else if (f2_turn_ff < TURN_W'(2 * SECTOR_SPAN)) begin
         sector   = SECTOR_GR;
         sec_base = TURN_W'(SECTOR_SPAN);
      end else if (f2_turn_ff < TURN_W'(3 * SECTOR_SPAN)) begin
         sector   = SECTOR_GB;
         sec_base = TURN_W'(2 * SECTOR_SPAN);
      end else if (f2_turn_ff < TURN_W'(4 * SECTOR_SPAN)) begin
         sector   = SECTOR_BG;
         sec_base = TURN_W'(3 * SECTOR_SPAN);
      end else if (f2_turn_ff < TURN_W'(5 * SECTOR_SPAN)) begin
         sector   = SECTOR_BR;
         sec_base = TURN_W'(4 * SECTOR_SPAN);
      end else begin
         sector   = SECTOR_RB;
         sec_base = TURN_W'(5 * SECTOR_SPAN);
      end
   end

   always_comb begin
      q_word.sector  = sector;
      q_word.rem     = REM_W'(f2_turn_ff - sec_base);
      q_word.sat_inv = f2_sinv_ff;
      q_word.val     = f2_val_ff;
   end

   `HSVC_ASSERT(a_turn_range, clock, reset, f2_valid_ff |-> (f2_turn_ff < TURN_W'(FULL_TURN)), "reduced hue out of range")

endmodule

// ----- rtl/hsvc_queue.sv -----
// Short word queue between the front end and the arithmetic back end.
// Depends on hsvc_pkg and the assertion header.
`include "hsv_to_rgb_converter_unit_assert.svh"
module hsvc_queue import hsvc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type push_word,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop,
   output word_type pop_word
);

   word_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   `HSVC_ASSERT(a_no_overflow, clock, reset, push |-> !full, "push into full queue")
   `HSVC_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "count past depth")

endmodule

// ----- rtl/hsvc_back.sv -----
// Arithmetic back end: six stalling stages from queue word to RGB output register.
// Depends on hsvc_pkg and the assertion header.
`include "hsv_to_rgb_converter_unit_assert.svh"
module hsvc_back import hsvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  word_type          q_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAN_W-1:0] rsp_red,
   output logic [CHAN_W-1:0] rsp_green,
   output logic [CHAN_W-1:0] rsp_blue
);

   localparam int unsigned NSTAGE = 6;

   logic [NSTAGE-1:0] valid_ff, valid_in;
   logic [NSTAGE:0]   rdy;

   // stage registers
   logic [CHAN_W-1:0] s1_top_ff;
   logic [PCT_W-1:0]  s1_sinv_ff;
   sector_type        s1_sec_ff;
   logic [REM_W-1:0]  s1_rem_ff;

   logic [14:0]       s2_prod_ff;
   logic [CHAN_W-1:0] s2_top_ff;
   sector_type        s2_sec_ff;
   logic [REM_W-1:0]  s2_rem_ff;

   logic [CHAN_W-1:0] s3_bot_ff;
   logic [CHAN_W-1:0] s3_top_ff;
   sector_type        s3_sec_ff;
   logic [REM_W-1:0]  s3_rem_ff;

   logic [13:0]       s4_dprod_ff;
   logic [CHAN_W-1:0] s4_top_ff;
   logic [CHAN_W-1:0] s4_bot_ff;
   sector_type        s4_sec_ff;

   logic [CHAN_W-1:0] s5_adj_ff;
   logic [CHAN_W-1:0] s5_top_ff;
   logic [CHAN_W-1:0] s5_bot_ff;
   sector_type        s5_sec_ff;

   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;

   logic [30:0]       top_mul, bot_mul;
   logic [CHAN_W-1:0] diff;
   logic [28:0]       adj_mul;
   logic [CHAN_W-1:0] rise, fall;
   logic [CHAN_W-1:0] red_in, green_in, blue_in;

   // ready ripples back from the output register
   always_comb begin
      rdy[NSTAGE] = rsp_ready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[0] = rdy[0] ? q_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign q_pop     = q_valid && rdy[0];
   assign rsp_valid = valid_ff[NSTAGE-1];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign top_mul = 31'(q_word.val) * 31'(TOP_SCALE);
   assign bot_mul = 31'(s2_prod_ff) * 31'(RECIP_PERCENT);
   assign diff    = s3_top_ff - s3_bot_ff;
   assign adj_mul = 29'(s4_dprod_ff) * 29'(RECIP_SPAN);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_top_ff  <= top_mul[PERCENT_SHIFT +: CHAN_W];
         s1_sinv_ff <= q_word.sat_inv;
         s1_sec_ff  <= q_word.sector;
         s1_rem_ff  <= q_word.rem;
      end
      if (rdy[1]) begin
         s2_prod_ff <= 15'(s1_top_ff) * 15'(s1_sinv_ff);
         s2_top_ff  <= s1_top_ff;
         s2_sec_ff  <= s1_sec_ff;
         s2_rem_ff  <= s1_rem_ff;
      end
      if (rdy[2]) begin
         s3_bot_ff <= bot_mul[PERCENT_SHIFT +: CHAN_W];
         s3_top_ff <= s2_top_ff;
         s3_sec_ff <= s2_sec_ff;
         s3_rem_ff <= s2_rem_ff;
      end
      if (rdy[3]) begin
         s4_dprod_ff <= 14'(diff) * 14'(s3_rem_ff);
         s4_top_ff   <= s3_top_ff;
         s4_bot_ff   <= s3_bot_ff;
         s4_sec_ff   <= s3_sec_ff;
      end
      if (rdy[4]) begin
         s5_adj_ff <= adj_mul[SPAN_SHIFT +: CHAN_W];
         s5_top_ff <= s4_top_ff;
         s5_bot_ff <= s4_bot_ff;
         s5_sec_ff <= s4_sec_ff;
      end
      if (rdy[5]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rise = s5_bot_ff + s5_adj_ff;
   assign fall = s5_top_ff - s5_adj_ff;

   always_comb begin
      case (s5_sec_ff)
         SECTOR_RG: begin
            red_in = s5_top_ff; green_in = rise;      blue_in = s5_bot_ff;
         end
         SECTOR_GR: begin
            red_in = fall;      green_in = s5_top_ff; blue_in = s5_bot_ff;
         end
         SECTOR_GB: begin
            red_in = s5_bot_ff; green_in = s5_top_ff; blue_in = rise;
         end
         SECTOR_BG: begin
            red_in = s5_bot_ff; green_in = fall;      blue_in = s5_top_ff;
         end
         SECTOR_BR: begin
            red_in = rise;      green_in = s5_bot_ff; blue_in = s5_top_ff;
         end
         default: begin
            red_in = s5_top_ff; green_in = s5_bot_ff; blue_in = fall;
         end
      endcase
   end

   `HSVC_ASSERT(a_bot_le_top, clock, reset, valid_ff[2] |-> (s3_bot_ff <= s3_top_ff), "min above max")
   `HSVC_ASSERT(a_adj_le_span, clock, reset, valid_ff[4] |-> (s5_adj_ff <= (s5_top_ff - s5_bot_ff)), "ramp beyond span")

endmodule

// ----- rtl/hsv_to_rgb_converter_unit.sv -----
// HSV to RGB converter: one word in, one RGB word out, pipelined at one word a cycle while rsp_ready does not stall.
// A request passes the front-end registers, the queue and the back-end stages to rsp_valid.
// Every stage is registered and can take a new word while it hands on its last one.
// A 4-word queue splits hue reduction from the arithmetic, so each side stalls on its own.
// Synchronous active-high reset empties the pipeline and queue; payload registers keep data.
// Depends on hsvc_pkg, hsvc_front, hsvc_queue, hsvc_back.
module hsv_to_rgb_converter_unit import hsvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [PCT_W-1:0]  req_saturation,
   input  logic [PCT_W-1:0]  req_brightness,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAN_W-1:0] rsp_red,
   output logic [CHAN_W-1:0] rsp_green,
   output logic [CHAN_W-1:0] rsp_blue
);

   logic     q_full, q_push, q_valid, q_pop;
   word_type push_word, pop_word;

   hsvc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_word         (push_word)
   );

   hsvc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_word  (pop_word)
   );

   hsvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_word    (pop_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule
